>>> design/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared constants and types of the Playfair digraph cipher block.
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int SQUARE_SIDE = 5;
   localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
   localparam int LETTER_W    = 5;
   localparam int CHAR_IN_W   = 8;
   localparam int CHAR_OUT_W  = 7;
   localparam int CSR_DATA_W  = 50;
   localparam int CSR_IDX_W   = 2;
   localparam int ROW_PAIR_W  = 2 * SQUARE_SIDE * LETTER_W;
   localparam int ROW_W       = SQUARE_SIDE * LETTER_W;
   localparam int MAX_RESULTS = 4;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W       = $clog2(MAX_RESULTS);

   localparam logic [LETTER_W-1:0] LETTER_I   = 5'd8;
   localparam logic [LETTER_W-1:0] LETTER_J   = 5'd9;
   localparam logic [LETTER_W-1:0] LETTER_X   = 5'd23;
   localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;

   localparam logic [CHAR_IN_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_IN_W-1:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [CHAR_IN_W-1:0] ASCII_LOWER_A = 8'h61;
   localparam logic [CHAR_IN_W-1:0] ASCII_LOWER_Z = 8'h7A;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIRECTION = 2'd0,
      CSR_ROWS_0_1  = 2'd1,
      CSR_ROWS_2_3  = 2'd2,
      CSR_ROW_4     = 2'd3
   } csr_index_type;

   // cell 0 in the lowest bits
   typedef logic [CELLS-1:0][LETTER_W-1:0] square_type;

   typedef struct packed {
      logic       decrypt;
      square_type square;
   } cfg_type;

   // up to two letter pairs per request, compacted into slot 0 first
   typedef struct packed {
      logic [1:0]          npairs;
      logic [LETTER_W-1:0] a0;
      logic [LETTER_W-1:0] b0;
      logic [LETTER_W-1:0] a1;
      logic [LETTER_W-1:0] b1;
      logic                msg_end;
   } job_type;

endpackage

>>> design/pfc_if.sv
// ----------------------------------------------------------------------------
// pfc_if
// Valid/ready channel interfaces: request, response and CSR write.
// ----------------------------------------------------------------------------
interface pfc_req_if import pfc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_IN_W-1:0] in_char;
   logic                 message_end;

   modport source (output valid, in_char, message_end, input ready);
   modport sink   (input valid, in_char, message_end, output ready);
endinterface

interface pfc_rsp_if import pfc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_OUT_W-1:0] out_char;
   logic                  run_last;
   logic                  message_done;

   modport source (output valid, out_char, run_last, message_done, input ready);
   modport sink   (input valid, out_char, run_last, message_done, output ready);
endinterface

interface pfc_csr_if import pfc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/pfc_csr.sv
// ----------------------------------------------------------------------------
// pfc_csr
// Configuration registers: direction and the 5x5 key square.
// ----------------------------------------------------------------------------
module pfc_csr import pfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   pfc_csr_if.sink  csr,
   output cfg_type  cfg
);

   logic                  decrypt_ff, decrypt_in;
   logic [ROW_PAIR_W-1:0] rows01_ff, rows01_in;
   logic [ROW_PAIR_W-1:0] rows23_ff, rows23_in;
   logic [ROW_W-1:0]      row4_ff, row4_in;

   assign csr.ready = 1'b1;

   always_comb begin
      decrypt_in = decrypt_ff;
      rows01_in  = rows01_ff;
      rows23_in  = rows23_ff;
      row4_in    = row4_ff;
      if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_DIRECTION: decrypt_in = csr.data[0];
            CSR_ROWS_0_1:  rows01_in  = csr.data[ROW_PAIR_W-1:0];
            CSR_ROWS_2_3:  rows23_in  = csr.data[ROW_PAIR_W-1:0];
            CSR_ROW_4:     row4_in    = csr.data[ROW_W-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_ff <= 1'b0;
         rows01_ff  <= '0;
         rows23_ff  <= '0;
         row4_ff    <= '0;
      end else begin
         decrypt_ff <= decrypt_in;
         rows01_ff  <= rows01_in;
         rows23_ff  <= rows23_in;
         row4_ff    <= row4_in;
      end
   end

   assign cfg.decrypt = decrypt_ff;
   assign cfg.square  = square_type'({row4_ff, rows23_ff, rows01_ff});

endmodule

>>> design/pfc_pair_stage.sv
// ----------------------------------------------------------------------------
// pfc_pair_stage
// Input register: letter filter, pending-letter pairing and job register.
// ----------------------------------------------------------------------------
module pfc_pair_stage import pfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   pfc_req_if.sink  req,
   input  logic     decrypt,
   input  logic     job_take,
   output job_type  job,
   output logic     job_valid
);

   logic                pend_valid_ff, pend_valid_in;
   logic [LETTER_W-1:0] pend_letter_ff, pend_letter_in;
   job_type             job_ff, job_in;
   logic                job_valid_ff, job_valid_in;

   logic                is_letter;
   logic [LETTER_W-1:0] letter;
   logic                accept;
   logic                pair0_v, pair1_v;
   logic [LETTER_W-1:0] b0, mid_letter;
   logic                mid_valid;

   assign req.ready = !job_valid_ff || job_take;
   assign accept    = req.valid && req.ready;

   // letter filter: A..Z / a..z to 0..25, J folds to I
   always_comb begin
      is_letter = 1'b0;
      letter    = '0;
      if (req.in_char >= ASCII_UPPER_A && req.in_char <= ASCII_UPPER_Z) begin
         is_letter = 1'b1;
         letter    = LETTER_W'(req.in_char - ASCII_UPPER_A);
      end else if (req.in_char >= ASCII_LOWER_A && req.in_char <= ASCII_LOWER_Z) begin
         is_letter = 1'b1;
         letter    = LETTER_W'(req.in_char - ASCII_LOWER_A);
      end
      if (letter == LETTER_J)
         letter = LETTER_I;
   end

   always_comb begin
      pair0_v    = 1'b0;
      b0         = letter;
      mid_valid  = pend_valid_ff;
      mid_letter = pend_letter_ff;
      if (is_letter) begin
         if (!pend_valid_ff) begin
            mid_valid  = 1'b1;
            mid_letter = letter;
         end else if (!decrypt && pend_letter_ff == letter) begin
            // doubled letter: pad with X, keep the letter pending
            pair0_v = 1'b1;
            b0      = LETTER_X;
         end else begin
            pair0_v    = 1'b1;
            mid_valid  = 1'b0;
            mid_letter = '0;
         end
      end
      // odd letter at message end: padded on encrypt, dropped on decrypt
      pair1_v = req.message_end && mid_valid && !decrypt;

      pend_valid_in  = pend_valid_ff;
      pend_letter_in = pend_letter_ff;
      if (accept) begin
         pend_valid_in  = mid_valid && !req.message_end;
         pend_letter_in = req.message_end ? '0 : mid_letter;
      end

      job_in         = job_ff;
      job_valid_in   = job_valid_ff && !job_take;
      if (accept) begin
         job_valid_in   = 1'b1;
         job_in.npairs  = 2'(pair0_v) + 2'(pair1_v);
         job_in.msg_end = req.message_end;
         job_in.a1      = mid_letter;
         job_in.b1      = LETTER_X;
         if (pair0_v) begin
            job_in.a0 = pend_letter_ff;
            job_in.b0 = b0;
         end else begin
            job_in.a0 = mid_letter;
            job_in.b0 = LETTER_X;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff  <= 1'b0;
         pend_letter_ff <= '0;
         job_valid_ff   <= 1'b0;
      end else begin
         pend_valid_ff  <= pend_valid_in;
         pend_letter_ff <= pend_letter_in;
         job_valid_ff   <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job       = job_ff;
   assign job_valid = job_valid_ff;

endmodule

>>> design/pfc_cipher.sv
// ----------------------------------------------------------------------------
// pfc_cipher
// One digraph through the key square: row shift, column shift or swap.
// ----------------------------------------------------------------------------
module pfc_cipher import pfc_pkg::*; (
   input  cfg_type               cfg,
   input  logic [LETTER_W-1:0]   letter_a,
   input  logic [LETTER_W-1:0]   letter_b,
   output logic [CHAR_OUT_W-1:0] char_a,
   output logic [CHAR_OUT_W-1:0] char_b
);

   typedef logic [2:0] coord_type;

   // lowest matching cell wins; no match falls back to cell 0
   function automatic void locate(input square_type sq, input logic [LETTER_W-1:0] l,
                                  output coord_type row, output coord_type col);
      row = '0;
      col = '0;
      for (int k = CELLS - 1; k >= 0; k--) begin
         if (sq[k] == l) begin
            row = coord_type'(k / SQUARE_SIDE);
            col = coord_type'(k % SQUARE_SIDE);
         end
      end
   endfunction

   function automatic coord_type shift(input coord_type x, input logic back);
      coord_type r;
      if (back)
         r = (x == '0) ? coord_type'(SQUARE_SIDE - 1) : x - 3'd1;
      else
         r = (x == coord_type'(SQUARE_SIDE - 1)) ? '0 : x + 3'd1;
      return r;
   endfunction

   function automatic logic [CHAR_OUT_W-1:0] cell_char(input square_type sq,
                                                       input coord_type row,
                                                       input coord_type col);
      logic [LETTER_W-1:0] k;
      logic [LETTER_W-1:0] v;
      k = LETTER_W'(row) * LETTER_W'(SQUARE_SIDE) + LETTER_W'(col);
      v = sq[k];
      if (v > LETTER_MAX)
         v = LETTER_MAX;
      return CHAR_OUT_W'(v) + CHAR_OUT_W'(ASCII_UPPER_A);
   endfunction

   coord_type ra, ca, rb, cb;
   coord_type ra_o, ca_o, rb_o, cb_o;

   always_comb begin
      locate(cfg.square, letter_a, ra, ca);
      locate(cfg.square, letter_b, rb, cb);
      ra_o = ra;
      ca_o = ca;
      rb_o = rb;
      cb_o = cb;
      if (ra == rb) begin
         ca_o = shift(ca, cfg.decrypt);
         cb_o = shift(cb, cfg.decrypt);
      end else if (ca == cb) begin
         ra_o = shift(ra, cfg.decrypt);
         rb_o = shift(rb, cfg.decrypt);
      end else begin
         ca_o = cb;
         cb_o = ca;
      end
      char_a = cell_char(cfg.square, ra_o, ca_o);
      char_b = cell_char(cfg.square, rb_o, cb_o);
   end

endmodule

>>> design/pfc_out_buffer.sv
// ----------------------------------------------------------------------------
// pfc_out_buffer
// Enciphers a job into up to four letters and hands them out one a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module pfc_out_buffer import pfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  job_type  job,
   input  logic     job_valid,
   output logic     job_take,
   pfc_rsp_if.source rsp
);

   logic [CHAR_OUT_W-1:0] chars_ff [MAX_RESULTS];
   logic [CHAR_OUT_W-1:0] chars_in [MAX_RESULTS];
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  end_ff, end_in;

   logic [CHAR_OUT_W-1:0] ca0, cb0, ca1, cb1;
   logic                  last;
   logic                  rsp_fire;

   pfc_cipher u_cipher0 (
      .cfg      (cfg),
      .letter_a (job.a0),
      .letter_b (job.b0),
      .char_a   (ca0),
      .char_b   (cb0)
   );

   pfc_cipher u_cipher1 (
      .cfg      (cfg),
      .letter_a (job.a1),
      .letter_b (job.b1),
      .char_a   (ca1),
      .char_b   (cb1)
   );

   assign last     = CNT_W'(idx_ff) == cnt_ff - CNT_W'(1);
   assign rsp_fire = rsp.valid && rsp.ready;
   assign job_take = job_valid && (cnt_ff == '0 || (rsp_fire && last));

   always_comb begin
      chars_in = chars_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      end_in   = end_ff;
      if (job_take) begin
         chars_in[0] = ca0;
         chars_in[1] = cb0;
         chars_in[2] = ca1;
         chars_in[3] = cb1;
         cnt_in      = CNT_W'({job.npairs, 1'b0});
         idx_in      = '0;
         end_in      = job.msg_end;
      end else if (rsp_fire) begin
         if (last)
            cnt_in = '0;
         else
            idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      end_ff   <= end_in;
   end

   assign rsp.valid        = cnt_ff != '0;
   assign rsp.out_char     = chars_ff[idx_ff];
   assign rsp.run_last     = last;
   assign rsp.message_done = last && end_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> CNT_W'(idx_ff) < cnt_ff)
      else $error("result index beyond loaded count");

   a_cnt_pairs: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] == 1'b0)
      else $error("result count not a whole number of pairs");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && last && !job_take |=> cnt_ff == '0)
      else $error("buffer not empty after last result without reload");

endmodule

>>> design/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Streaming Playfair digraph cipher over a configured 5x5 key square.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  : one message byte per request; message_end marks the last byte.
//              Non-letters are dropped, letters folded to upper case, J to I.
//   rsp_bus  : result letters 'A'..'Z', 0 to 4 per request. run_last flags the
//              last letter of a request, message_done the last of a message.
//   csr_bus  : register writes (0 direction, 1-3 key square rows); write only
//              while no request is in flight. Always ready.
// A request accepted passes the job register, then the output buffer, before
// its first letter shows. Requests go in one per cycle while nothing is emitted;
// a request that yields letters holds the output buffer until its last letter is
// taken. The job register takes the next request while letters still drain.
// Reset clears the registers, the pending letter and both pipeline stages.
// A stalled receiver holds the current letter; the job register then fills
// and req_bus.ready drops until the buffer frees up.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher import pfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pfc_req_if.sink    req_bus,
   pfc_rsp_if.source  rsp_bus,
   pfc_csr_if.sink    csr_bus
);

   cfg_type cfg;
   job_type job;
   logic    job_valid;
   logic    job_take;

   pfc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   pfc_pair_stage u_pair_stage (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .decrypt   (cfg.decrypt),
      .job_take  (job_take),
      .job       (job),
      .job_valid (job_valid)
   );

   pfc_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job       (job),
      .job_valid (job_valid),
      .job_take  (job_take),
      .rsp       (rsp_bus)
   );

endmodule

>>> tb/playfair_digraph_cipher_tb.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_tb
// Streams message bytes through the cipher under several key squares and
// both directions. A scoreboard predicts each request's letters and checks
// them field by field. Both ends idle at random, the receiver holds off long
// enough once to back up the input, and the last phase runs at full rate.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_tb import pfc_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int PHASES           = 6;
   localparam int PHASE_ITEMS      = 30;

   typedef struct packed {
      logic [CHAR_OUT_W-1:0] out_char;
      logic                  run_last;
      logic                  message_done;
   } cipher_letter_type;

   class digraph_scoreboard;
      logic                decrypt;
      square_type          square;
      logic [LETTER_W-1:0] held_letter;
      logic                held_valid;
      cipher_letter_type   expected_q[$];
      int                  errors;

      function new();
         decrypt     = 1'b0;
         square      = '0;
         held_letter = '0;
         held_valid  = 1'b0;
         errors      = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DIRECTION: decrypt = data[0];
            CSR_ROWS_0_1:  square[9:0] = data;
            CSR_ROWS_2_3:  square[19:10] = data;
            CSR_ROW_4:     square[24:20] = data[ROW_W-1:0];
            default: ;
         endcase
      endfunction

      // first cell holding the letter; a missing letter sits at cell 0
      function int locate(logic [LETTER_W-1:0] letter);
         for (int k = 0; k < CELLS; k++)
            if (square[k] == letter) return k;
         return 0;
      endfunction

      function logic [CHAR_OUT_W-1:0] letter_at(int k);
         logic [LETTER_W-1:0] v;
         v = square[k];
         if (v > LETTER_MAX) v = LETTER_MAX;
         return CHAR_OUT_W'(ASCII_UPPER_A + v);
      endfunction

      function void cipher_pair(logic [LETTER_W-1:0] a, logic [LETTER_W-1:0] b);
         int ka, kb, ra, ca, rb, cb, shift, t;
         cipher_letter_type r;
         ka = locate(a);
         kb = locate(b);
         ra = ka / SQUARE_SIDE;
         ca = ka % SQUARE_SIDE;
         rb = kb / SQUARE_SIDE;
         cb = kb % SQUARE_SIDE;
         shift = decrypt ? SQUARE_SIDE - 1 : 1;
         if (ra == rb) begin
            ca = (ca + shift) % SQUARE_SIDE;
            cb = (cb + shift) % SQUARE_SIDE;
         end else if (ca == cb) begin
            ra = (ra + shift) % SQUARE_SIDE;
            rb = (rb + shift) % SQUARE_SIDE;
         end else begin
            t  = ca;
            ca = cb;
            cb = t;
         end
         r.run_last     = 1'b0;
         r.message_done = 1'b0;
         r.out_char     = letter_at(ra * SQUARE_SIDE + ca);
         expected_q.push_back(r);
         r.out_char     = letter_at(rb * SQUARE_SIDE + cb);
         expected_q.push_back(r);
      endfunction

      function void accept_byte(logic [CHAR_IN_W-1:0] ch, logic msg_end);
         int                  old_count;
         logic [LETTER_W-1:0] l;
         logic                is_letter;
         cipher_letter_type   r;
         old_count = expected_q.size();
         is_letter = 1'b1;
         l         = '0;
         if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z)
            l = LETTER_W'(ch - ASCII_UPPER_A);
         else if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z)
            l = LETTER_W'(ch - ASCII_LOWER_A);
         else
            is_letter = 1'b0;
         if (is_letter && l == LETTER_J) l = LETTER_I;
         if (is_letter) begin
            if (!held_valid) begin
               held_letter = l;
               held_valid  = 1'b1;
            end else if (!decrypt && held_letter == l) begin
               // doubled letter: pair with X, keep the letter held
               cipher_pair(held_letter, LETTER_X);
            end else begin
               cipher_pair(held_letter, l);
               held_valid  = 1'b0;
               held_letter = '0;
            end
         end
         if (msg_end) begin
            if (held_valid && !decrypt) cipher_pair(held_letter, LETTER_X);
            held_valid  = 1'b0;
            held_letter = '0;
         end
         if (expected_q.size() > old_count) begin
            r = expected_q.pop_back();
            r.run_last     = 1'b1;
            r.message_done = msg_end;
            expected_q.push_back(r);
         end
      endfunction

      function void check_letter(logic [CHAR_OUT_W-1:0] ch, logic last, logic done);
         cipher_letter_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected letter: expected none, got %c", $time, ch);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (ch !== want.out_char) begin
               $display("%0t: out_char expected %c got %c", $time, want.out_char, ch);
               errors++;
            end
            if (last !== want.run_last) begin
               $display("%0t: run_last expected %b got %b", $time, want.run_last, last);
               errors++;
            end
            if (done !== want.message_done) begin
               $display("%0t: message_done expected %b got %b", $time,
                        want.message_done, done);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   stalls_on = 1'b1;
   bit   gaps_on   = 1'b1;
   bit   long_hold = 1'b0;
   int   cycle_count = 0;

   digraph_scoreboard sb;

   pfc_req_if req_bus ();
   pfc_rsp_if rsp_bus ();
   pfc_csr_if csr_bus ();

   playfair_digraph_cipher uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("playfair_digraph_cipher_tb NOT OK");
         $finish;
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_letter(rsp_bus.out_char, rsp_bus.run_last, rsp_bus.message_done);

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_byte(logic [CHAR_IN_W-1:0] ch, logic msg_end);
      req_bus.valid       <= 1'b1;
      req_bus.in_char     <= ch;
      req_bus.message_end <= msg_end;
      do @(posedge clock); while (!req_bus.ready);
      sb.accept_byte(ch, msg_end);
      @(negedge clock);
   endtask

   task automatic pause_requests(int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // wait for every predicted letter, then let a dropped request clear the pipe
   task automatic wait_for_letters();
      req_bus.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_register(idx, data);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_key(square_type sq, logic dir);
      write_csr(CSR_DIRECTION, CSR_DATA_W'(dir));
      write_csr(CSR_ROWS_0_1, sq[9:0]);
      write_csr(CSR_ROWS_2_3, sq[19:10]);
      write_csr(CSR_ROW_4, CSR_DATA_W'(sq[24:20]));
   endtask

   // 0: proper square, 1: raw bits, 2: letters with repeats, 3: all ones
   function automatic square_type random_square(int kind);
      square_type          sq;
      logic [LETTER_W-1:0] pool[CELLS];
      logic [LETTER_W-1:0] t;
      int                  n, j;
      sq = '0;
      case (kind)
         0: begin
            n = 0;
            for (int v = 0; v <= LETTER_MAX; v++)
               if (v != LETTER_J) begin
                  pool[n] = LETTER_W'(v);
                  n++;
               end
            for (int k = CELLS - 1; k > 0; k--) begin
               j       = $urandom_range(0, k);
               t       = pool[k];
               pool[k] = pool[j];
               pool[j] = t;
            end
            for (int k = 0; k < CELLS; k++) sq[k] = pool[k];
         end
         1: for (int k = 0; k < CELLS; k++) sq[k] = LETTER_W'($urandom_range(0, 31));
         2: for (int k = 0; k < CELLS; k++) sq[k] = LETTER_W'($urandom_range(0, 25));
         default: sq = '1;
      endcase
      return sq;
   endfunction

   // mostly letters of both cases, some doubles, some raw bytes
   function automatic logic [CHAR_IN_W-1:0] pick_byte(logic [CHAR_IN_W-1:0] prev);
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return CHAR_IN_W'($urandom_range(0, 255));
      else if (r < 24) return prev;
      else if (r < 28) return "X";
      else if (r < 31) return "j";
      else if (r < 66) return CHAR_IN_W'(ASCII_UPPER_A + $urandom_range(0, 25));
      else return CHAR_IN_W'(ASCII_LOWER_A + $urandom_range(0, 25));
   endfunction

   initial begin
      string               keyed;
      square_type          sq;
      logic [CHAR_IN_W-1:0] prev, ch;
      logic                msg_end;

      sb    = new();
      keyed = "PLAYFIREXMBCDGHKNOQSTUVWZ";
      prev  = "A";
      reset = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.in_char     = '0;
      req_bus.message_end = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_DIRECTION;
      csr_bus.data        = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset square: every cell holds A
      send_byte("A", 1'b0);
      send_byte("b", 1'b1);
      wait_for_letters();

      for (int k = 0; k < CELLS; k++) sq[k] = LETTER_W'(keyed[k] - ASCII_UPPER_A);
      load_key(sq, 1'b0);
      send_byte("h", 1'b0);    // lower case, rectangle
      send_byte("j", 1'b0);    // J folds to I
      send_byte("D", 1'b0);    // same column
      send_byte("E", 1'b0);
      send_byte("P", 1'b0);    // same row, wraps
      send_byte("F", 1'b0);
      send_byte("E", 1'b0);    // doubled pair, E stays held
      send_byte("E", 1'b0);
      send_byte("Z", 1'b0);
      send_byte("X", 1'b0);    // double X
      send_byte("X", 1'b0);
      send_byte("{", 1'b1);    // end on a non-letter flushes held X
      send_byte(8'hFF, 1'b1);  // end with nothing held
      send_byte("A", 1'b1);    // odd letter padded
      send_byte("A", 1'b0);    // held across a direction change
      wait_for_letters();
      write_csr(CSR_DIRECTION, CSR_DATA_W'(1'b1));
      send_byte("A", 1'b0);    // identical pair when decrypting
      send_byte("B", 1'b0);
      send_byte("Z", 1'b0);
      send_byte("C", 1'b0);
      send_byte("U", 1'b0);
      send_byte("Q", 1'b1);    // odd letter dropped

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_letters();
         stalls_on = (phase != 2) && (phase != PHASES - 1);
         gaps_on   = (phase != 3) && (phase != PHASES - 1);
         load_key(random_square(phase % 4), phase[0]);
         if (phase == 0) long_hold = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (gaps_on && !long_hold && $urandom_range(0, 4) == 0)
               pause_requests($urandom_range(1, 16));
            ch      = pick_byte(prev);
            prev    = ch;
            msg_end = ($urandom_range(0, 9) == 0);
            send_byte(ch, msg_end);
         end
      end

      wait_for_letters();
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("playfair_digraph_cipher_tb OK");
      else
         $display("playfair_digraph_cipher_tb NOT OK");
      $finish;
   end

endmodule
